### rtl/pulse_rate_spo2_alarm_monitor_assert.svh
// Assertion macros shared by the monitor RTL.
`ifndef PULSE_RATE_SPO2_ALARM_MONITOR_ASSERT_SVH
`define PULSE_RATE_SPO2_ALARM_MONITOR_ASSERT_SVH

// Checks that the condition holds in the same cycle as the trigger.
`define PRSAM_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("monitor assertion failed");

// Checks that the condition holds in the cycle after the trigger.
`define PRSAM_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("monitor assertion failed");

`endif

### rtl/prsam_pkg.sv
`default_nettype none

package prsam_pkg;

    localparam int WINDOW_LEN_DEF = 5;

    localparam int TS_W     = 32;
    localparam int LEVEL_W  = 12;
    localparam int FOLD_W   = 13;
    localparam int RATE_W   = 17;
    localparam int BPM_W    = 9;
    localparam int SPO2_W   = 7;
    localparam int ALARM_W  = 3;
    localparam int RUN_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [63:0] MINUTE_US = 64'd60000000;

    localparam logic [RATE_W-1:0] RATE_Q8_MAX = 17'd76800;
    localparam logic [RATE_W-1:0] RATE_Q8_40  = 17'd10240;
    localparam logic [RATE_W-1:0] RATE_Q8_60  = 17'd15360;
    localparam logic [RATE_W-1:0] RATE_Q8_100 = 17'd25600;
    localparam logic [RATE_W-1:0] RATE_Q8_120 = 17'd30720;

    localparam logic [BPM_W-1:0] BPM_40  = 9'd40;
    localparam logic [BPM_W-1:0] BPM_60  = 9'd60;
    localparam logic [BPM_W-1:0] BPM_100 = 9'd100;
    localparam logic [BPM_W-1:0] BPM_120 = 9'd120;

    localparam logic [TS_W-1:0]   DEBOUNCE_RST = 32'd200000;
    localparam logic [RUN_W-1:0]  PERSIST_RST  = 8'd5;
    localparam logic [RUN_W-1:0]  RUN_MAX      = 8'd255;
    localparam logic [SPO2_W-1:0] SPO2_BASE    = 7'd80;

    localparam logic [LEVEL_W-1:0] FOLD_LOW  = 12'd2000;
    localparam logic [LEVEL_W-1:0] FOLD_HIGH = 12'd2100;
    localparam logic [FOLD_W-1:0]  FOLD_FULL = 13'd4096;
    localparam logic [FOLD_W-1:0]  FOLD_MID  = 13'd2048;
    localparam logic [FOLD_W-1:0]  SUM_CRIT  = 13'd1024;
    localparam logic [FOLD_W-1:0]  SUM_LOW   = 13'd2048;

    localparam logic [ALARM_W-1:0] ALARM_NORMAL    = 3'd0;
    localparam logic [ALARM_W-1:0] ALARM_RATE_ALT  = 3'd1;
    localparam logic [ALARM_W-1:0] ALARM_SPO2_LOW  = 3'd2;
    localparam logic [ALARM_W-1:0] ALARM_RATE_CRIT = 3'd3;
    localparam logic [ALARM_W-1:0] ALARM_SPO2_CRIT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST  = 1'd1;

    localparam logic CMD_BEAT   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic [BPM_W-1:0] bpm;
        logic [RUN_W-1:0] altered_run;
        logic [RUN_W-1:0] critical_run;
        logic [RUN_W-1:0] persist_count;
        logic             low_flag;
        logic             critical_flag;
    } t_spo2_ctx;

    typedef struct packed {
        logic [SPO2_W-1:0]  spo2;
        logic               low_flag;
        logic               critical_flag;
        logic [ALARM_W-1:0] alarm;
    } t_spo2_res;

    function automatic logic [FOLD_W-1:0] fold_channel(input logic [LEVEL_W-1:0] v);
        logic [FOLD_W-1:0] r;
        if (v < FOLD_LOW) begin
            r = FOLD_W'(v);
        end else if (v > FOLD_HIGH) begin
            r = FOLD_FULL - FOLD_W'(v);
        end else begin
            r = FOLD_MID;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/prsam_if.sv
`default_nettype none

interface prsam_in_if import prsam_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [TS_W-1:0]    timestamp_us;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] infrared_level;

    modport source (output valid, command, timestamp_us, red_level, infrared_level,
                    input ready);
    modport sink (input valid, command, timestamp_us, red_level, infrared_level,
                  output ready);
endinterface

interface prsam_out_if import prsam_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               beat_accepted;
    logic [BPM_W-1:0]   rate_bpm;
    logic [SPO2_W-1:0]  spo2_percent;
    logic [ALARM_W-1:0] alarm_code;

    modport source (output valid, beat_accepted, rate_bpm, spo2_percent, alarm_code,
                    input ready);
    modport sink (input valid, beat_accepted, rate_bpm, spo2_percent, alarm_code,
                  output ready);
endinterface

interface prsam_cfg_if import prsam_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/pulse_rate_spo2_alarm_monitor.sv
// A beat that fills the window passes the SUM, PREP, DIV, SAT, BAND and FIN states;
// the window sum, the dividend and the restoring division all run on the shared adder.
// Other beats pass BAND and FIN; samples and rejected beats go straight to FIN.
// One item is in flight at a time; a new one is taken once the result is registered.
// Reset is synchronous and active low; it restores control, state and configuration at once.
`default_nettype none

module pulse_rate_spo2_alarm_monitor import prsam_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prsam_in_if.sink    i_in,
    prsam_out_if.source o_out,
    prsam_cfg_if.sink   i_cfg
);

    `include "pulse_rate_spo2_alarm_monitor_assert.svh"

    localparam int          SUM_W  = TS_W + $clog2(WINDOW_LEN);
    localparam logic [63:0] NUM    = MINUTE_US * 64'(WINDOW_LEN) * 64'd256;
    localparam int          DIV_W  = $clog2(NUM + (64'd1 << (SUM_W - 1)));
    localparam int          ALU_W  = (DIV_W > SUM_W + 1) ? DIV_W : SUM_W + 1;
    localparam int          ALU_N  = ALU_W + 1;
    localparam int          CNT_W  = $clog2(ALU_W + 1);
    localparam int          WIN_IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int          BS_W   = $clog2(WINDOW_LEN + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;
    localparam logic [2:0] ST_BAND = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TS_W-1:0]    r_debounce, n_debounce;
    logic [RUN_W-1:0]   r_persist, n_persist;
    logic [TS_W-1:0]    r_last, n_last;
    logic [TS_W-1:0]    r_win [WINDOW_LEN];
    logic [TS_W-1:0]    n_win [WINDOW_LEN];
    logic [BS_W-1:0]    r_beats, n_beats;
    logic [RATE_W-1:0]  r_rate, n_rate;
    logic [RUN_W-1:0]   r_alt_run, n_alt_run;
    logic [RUN_W-1:0]   r_crit_run, n_crit_run;
    logic               r_low, n_low;
    logic               r_crit, n_crit;
    logic [SPO2_W-1:0]  r_spo2, n_spo2;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [DIV_W-1:0]   r_dvd, n_dvd;
    logic [SUM_W-1:0]   r_rem, n_rem;
    logic               r_acc, n_acc;
    logic [ALARM_W-1:0] r_alarm, n_alarm;
    logic               r_out_valid, n_out_valid;
    logic               r_out_acc, n_out_acc;
    logic [BPM_W-1:0]   r_out_bpm, n_out_bpm;
    logic [SPO2_W-1:0]  r_out_spo2, n_out_spo2;
    logic [ALARM_W-1:0] r_out_alarm, n_out_alarm;

    logic [ALU_N-1:0]   w_alu_a, w_alu_b, w_alu_y;
    logic               w_alu_sub;
    logic [SUM_W:0]     w_shift;
    logic [TS_W-1:0]    w_delta;
    logic [RATE_W-1:0]  w_bpm_sum;
    logic [BPM_W-1:0]   w_bpm;
    logic               w_in_xfer;
    t_spo2_ctx          w_ctx;
    t_spo2_res          w_res;

    assign w_in_xfer = i_in.valid && i_in.ready;
    assign w_delta   = i_in.timestamp_us - r_last;
    assign w_bpm_sum = r_rate + RATE_W'(128);
    assign w_bpm     = w_bpm_sum[RATE_W-1:8];
    assign w_shift   = {r_rem, r_dvd[DIV_W-1]};

    assign w_ctx.bpm           = w_bpm;
    assign w_ctx.altered_run   = r_alt_run;
    assign w_ctx.critical_run  = r_crit_run;
    assign w_ctx.persist_count = r_persist;
    assign w_ctx.low_flag      = r_low;
    assign w_ctx.critical_flag = r_crit;

    prsam_spo2 u_spo2 (
        .i_red_level      (i_in.red_level),
        .i_infrared_level (i_in.infrared_level),
        .i_ctx            (w_ctx),
        .o_res            (w_res)
    );

    // Shared adder: accumulates the window, forms the dividend and runs the division.
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        case (r_state)
            ST_SUM: begin
                w_alu_a = ALU_N'(r_sum);
                w_alu_b = ALU_N'(r_win[r_cnt[WIN_IW-1:0]]);
            end
            ST_PREP: begin
                w_alu_a = ALU_N'(NUM);
                w_alu_b = ALU_N'(r_sum >> 1);
            end
            ST_DIV: begin
                w_alu_a   = ALU_N'(w_shift);
                w_alu_b   = ALU_N'(r_sum);
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_a = '0;
            end
        endcase
    end

    assign w_alu_y = w_alu_a + (w_alu_sub ? ~w_alu_b : w_alu_b) + ALU_N'(w_alu_sub);

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.beat_accepted = r_out_acc;
    assign o_out.rate_bpm      = r_out_bpm;
    assign o_out.spo2_percent  = r_out_spo2;
    assign o_out.alarm_code    = r_out_alarm;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_debounce  = r_debounce;
        n_persist   = r_persist;
        n_last      = r_last;
        n_win       = r_win;
        n_beats     = r_beats;
        n_rate      = r_rate;
        n_alt_run   = r_alt_run;
        n_crit_run  = r_crit_run;
        n_low       = r_low;
        n_crit      = r_crit;
        n_spo2      = r_spo2;
        n_sum       = r_sum;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_acc       = r_acc;
        n_alarm     = r_alarm;
        n_out_valid = r_out_valid;
        n_out_acc   = r_out_acc;
        n_out_bpm   = r_out_bpm;
        n_out_spo2  = r_out_spo2;
        n_out_alarm = r_out_alarm;

        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_DEBOUNCE: n_debounce = i_cfg.data;
                CFG_PERSIST:  n_persist  = i_cfg.data[RUN_W-1:0];
                default:      n_debounce = r_debounce;
            endcase
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_alarm = ALARM_NORMAL;
                    n_acc   = 1'b0;
                    n_state = ST_FIN;
                    if (i_in.command == CMD_SAMPLE) begin
                        n_spo2  = w_res.spo2;
                        n_low   = w_res.low_flag;
                        n_crit  = w_res.critical_flag;
                        n_alarm = w_res.alarm;
                    end else if (w_delta > r_debounce) begin
                        n_acc  = 1'b1;
                        n_last = i_in.timestamp_us;
                        for (int k = 1; k < WINDOW_LEN; k++) begin
                            n_win[k] = r_win[k-1];
                        end
                        n_win[0] = w_delta;
                        if (r_beats < BS_W'(WINDOW_LEN)) begin
                            n_beats = r_beats + BS_W'(1);
                        end
                        if (n_beats == BS_W'(WINDOW_LEN)) begin
                            n_sum   = '0;
                            n_cnt   = '0;
                            n_state = ST_SUM;
                        end else begin
                            n_state = ST_BAND;
                        end
                    end
                end
            end
            ST_SUM: begin
                n_sum = w_alu_y[SUM_W-1:0];
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(WINDOW_LEN - 1)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_dvd   = w_alu_y[DIV_W-1:0];
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!w_alu_y[ALU_W]) begin
                    n_rem = w_alu_y[SUM_W-1:0];
                end else begin
                    n_rem = w_shift[SUM_W-1:0];
                end
                n_dvd = {r_dvd[DIV_W-2:0], !w_alu_y[ALU_W]};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                if (r_dvd > DIV_W'(RATE_Q8_MAX)) begin
                    n_rate = RATE_Q8_MAX;
                end else begin
                    n_rate = r_dvd[RATE_W-1:0];
                end
                n_state = ST_BAND;
            end
            ST_BAND: begin
                if (((r_rate > RATE_Q8_100) && (r_rate < RATE_Q8_120)) ||
                    ((r_rate < RATE_Q8_60) && (r_rate > RATE_Q8_40))) begin
                    n_alt_run  = (r_alt_run < RUN_MAX) ? r_alt_run + RUN_W'(1) : RUN_MAX;
                    n_crit_run = '0;
                end else if ((r_rate > RATE_Q8_120) || (r_rate < RATE_Q8_40)) begin
                    n_crit_run = (r_crit_run < RUN_MAX) ? r_crit_run + RUN_W'(1) : RUN_MAX;
                    n_alt_run  = '0;
                end else begin
                    n_alt_run  = '0;
                    n_crit_run = '0;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_acc;
                    n_out_bpm   = w_bpm;
                    n_out_spo2  = r_spo2;
                    n_out_alarm = r_alarm;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_debounce  <= DEBOUNCE_RST;
            r_persist   <= PERSIST_RST;
            r_last      <= '0;
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_beats     <= '0;
            r_rate      <= '0;
            r_alt_run   <= '0;
            r_crit_run  <= '0;
            r_low       <= 1'b0;
            r_crit      <= 1'b0;
            r_spo2      <= SPO2_BASE;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_debounce  <= n_debounce;
            r_persist   <= n_persist;
            r_last      <= n_last;
            r_win       <= n_win;
            r_beats     <= n_beats;
            r_rate      <= n_rate;
            r_alt_run   <= n_alt_run;
            r_crit_run  <= n_crit_run;
            r_low       <= n_low;
            r_crit      <= n_crit;
            r_spo2      <= n_spo2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_acc       <= n_acc;
        r_alarm     <= n_alarm;
        r_out_acc   <= n_out_acc;
        r_out_bpm   <= n_out_bpm;
        r_out_spo2  <= n_out_spo2;
        r_out_alarm <= n_out_alarm;
    end

    `PRSAM_ASSERT_NOW(a_beats_bound, 1'b1, r_beats <= BS_W'(WINDOW_LEN))
    `PRSAM_ASSERT_NOW(a_rem_below_divisor, r_state == ST_DIV, r_rem < r_sum)
    `PRSAM_ASSERT_NOW(a_rate_saturated, r_state == ST_BAND, r_rate <= RATE_Q8_MAX)
    `PRSAM_ASSERT_NEXT(a_busy_after_transfer, w_in_xfer, r_state != ST_IDLE)
    `PRSAM_ASSERT_NOW(a_beat_no_alarm, r_out_valid && r_out_acc, r_out_alarm == ALARM_NORMAL)

endmodule

`default_nettype wire

### rtl/prsam_spo2.sv
`default_nettype none

module prsam_spo2 import prsam_pkg::*; (
    input  logic [LEVEL_W-1:0] i_red_level,
    input  logic [LEVEL_W-1:0] i_infrared_level,
    input  t_spo2_ctx          i_ctx,
    output t_spo2_res          o_res
);

    logic [FOLD_W-1:0] w_sum;
    logic [14:0]       w_scaled;
    logic [14:0]       w_round;
    logic              w_rate_alt;
    logic              w_rate_crit;

    assign w_sum    = fold_channel(i_red_level) + fold_channel(i_infrared_level);
    assign w_scaled = {w_sum, 2'b00} + 15'(w_sum);
    assign w_round  = w_scaled + 15'd512;

    assign w_rate_alt  = ((i_ctx.bpm > BPM_100) || (i_ctx.bpm < BPM_60))
                         && (i_ctx.altered_run >= i_ctx.persist_count);
    assign w_rate_crit = ((i_ctx.bpm > BPM_120) || (i_ctx.bpm < BPM_40))
                         && (i_ctx.critical_run >= i_ctx.persist_count);

    always_comb begin
        logic w_low;
        logic w_crit;
        w_low  = i_ctx.low_flag;
        w_crit = i_ctx.critical_flag;
        if ((w_sum > SUM_CRIT) && (w_sum < SUM_LOW)) begin
            w_low  = 1'b1;
            w_crit = 1'b0;
        end else if (w_sum < SUM_CRIT) begin
            w_crit = 1'b1;
            w_low  = 1'b0;
        end

        o_res.spo2 = SPO2_BASE + SPO2_W'(w_round[14:10]);
        o_res.alarm = ALARM_NORMAL;
        if (w_rate_alt) begin
            o_res.alarm = ALARM_RATE_ALT;
        end else if (w_low) begin
            o_res.alarm = ALARM_SPO2_LOW;
            w_low = 1'b0;
        end else if (w_rate_crit) begin
            o_res.alarm = ALARM_RATE_CRIT;
        end else if (w_crit) begin
            o_res.alarm = ALARM_SPO2_CRIT;
            w_crit = 1'b0;
        end
        o_res.low_flag      = w_low;
        o_res.critical_flag = w_crit;
    end

endmodule

`default_nettype wire
